// ===== design/sha_pkg.sv =====
package sha_pkg;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Queue entry between the byte front end and the compression back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_item_t;

  // Control from the back end to the compression engine.
  typedef struct packed {
    logic start;
    logic first;
  } sha_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      unique case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] i);
    logic [31:0] h;
    begin
      unique case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== design/sha_queue.sv =====
module sha_queue
  import sha_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_stall,
  input  sha_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_take,
  output sha_item_t rd_item
);
  localparam int AW = $clog2(Depth);

  sha_item_t         slots [Depth];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              push;
  logic              pop;

  assign wr_stall = (count == (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(Depth)) else $error("queue count out of range");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == (AW+1)'(Depth)) |-> wr_stall) else $error("full queue not stalling");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1)) else $error("pop lost");

endmodule

// ===== design/sha_core.sv =====
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sha_cmd_t    cmd,
  input  logic [31:0] w_in,
  output logic [5:0]  round,
  output logic        busy,
  output logic        done,
  output logic [31:0] hv [8]
);
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w [16];
  logic [31:0] wt, t1, t2, s0w, s1w;
  logic        run;
  logic [5:0]  rnd;

  assign round = rnd;
  assign busy  = run;

  always_comb begin
    s0w = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1w = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt  = (rnd < 6'd16) ? w_in : (w[0] + s0w + w[9] + s1w);
    t1  = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
        + round_k(rnd) + wt;
    t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  // w[] is a 16-word window; the newest word enters at w[15].
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= initial_h(3'(i));
    end else begin
      done <= run && (rnd == 6'd63);
      if (cmd.first) begin
        for (int i = 0; i < 8; i++) hv[i] <= initial_h(3'(i));
      end
      if (cmd.start && !run) begin
        run <= 1'b1;
        rnd <= '0;
        {a, b, c, d} <= cmd.first ? {initial_h(3'd0), initial_h(3'd1),
                                     initial_h(3'd2), initial_h(3'd3)}
                                  : {hv[0], hv[1], hv[2], hv[3]};
        {e, f, g, h} <= cmd.first ? {initial_h(3'd4), initial_h(3'd5),
                                     initial_h(3'd6), initial_h(3'd7)}
                                  : {hv[4], hv[5], hv[6], hv[7]};
      end else if (run) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wt;
        h <= g; g <= f; f <= e; e <= d + t1;
        d <= c; c <= b; b <= a; a <= t1 + t2;
        rnd <= rnd + 1'b1;
        if (rnd == 6'd63) begin
          run  <= 1'b0;
          hv[0] <= hv[0] + t1 + t2; hv[1] <= hv[1] + a;
          hv[2] <= hv[2] + b;       hv[3] <= hv[3] + c;
          hv[4] <= hv[4] + d + t1;  hv[5] <= hv[5] + e;
          hv[6] <= hv[6] + f;       hv[7] <= hv[7] + g;
        end
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run) && !run) else $error("done without a compression");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (run && rnd != 6'd63) |=> run) else $error("compression cut short");
  a_round_steps: assert property (@(posedge clk) disable iff (rst)
    ($past(run) && run) |-> rnd == $past(rnd) + 1'b1) else $error("round skipped");

endmodule

// ===== design/sha_back.sv =====
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_take,
  input  sha_item_t   q_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  typedef enum logic [5:0] {
    S_BYTE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_COMP = 6'b001000,
    S_OUT  = 6'b010000,
    S_FILL = 6'b100000
  } state_t;

  state_t      state;
  logic [63:0] count;
  logic [5:0]  bpos;       // byte slot in current block
  logic [31:0] words [16];
  logic        fresh;      // chain value still initial
  logic        final_blk;  // block in flight ends the message
  logic        pend_len;   // length still owed to a further padding block
  logic [2:0]  oidx;
  logic [5:0]  round;
  logic        busy, done;
  logic [31:0] hv [8];
  sha_cmd_t    cmd;
  logic        start_req;
  logic        len_here;   // length field goes in the block being padded
  logic [63:0] bits;
  logic [7:0]  pad_byte;

  assign bits      = count << 3;
  assign len_here  = (count[5:0] < 6'd56) || pend_len;
  assign start_req = (bpos == 6'd63)
                     && ((q_take && q_item.byte_present) || state == S_PAD || state == S_LEN);

  sha_core u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .w_in(words[round[3:0]]),
    .round(round), .busy(busy), .done(done), .hv(hv)
  );

  assign q_take = q_valid && (state == S_BYTE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = hv[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // Padding bytes: zeros, then the big-endian bit length in the last eight slots.
  always_comb begin
    if (state == S_LEN && len_here && bpos >= 6'd56) begin
      pad_byte = bits[8*(63 - bpos[5:0]) +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= '0;
    end else begin
      cmd <= '{start: start_req, first: start_req && fresh};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BYTE;
      count     <= '0;
      bpos      <= '0;
      fresh     <= 1'b1;
      final_blk <= 1'b0;
      pend_len  <= 1'b0;
      oidx      <= '0;
    end else begin
      if (start_req) fresh <= 1'b0;
      unique case (state)
        S_BYTE: begin
          if (q_take) begin
            if (q_item.byte_present) begin
              words[bpos[5:2]][8*(3 - bpos[1:0]) +: 8] <= q_item.data_byte;
              count <= count + 1'b1;
              bpos  <= bpos + 1'b1;
              if (bpos == 6'd63) begin
                final_blk <= 1'b0;
                state     <= q_item.end_of_message ? S_FILL : S_COMP;
              end else if (q_item.end_of_message) begin
                state <= S_PAD;
              end
            end else if (q_item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_FILL: begin
          // wait for full-block compression, then pad a fresh block
          if (done) begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          words[bpos[5:2]][8*(3 - bpos[1:0]) +: 8] <= PAD_MARK;
          bpos <= bpos + 1'b1;
          if (bpos == 6'd63) begin
            // marker closes the block; length goes in one more block
            final_blk <= 1'b0;
            pend_len  <= 1'b1;
            state     <= S_COMP;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          words[bpos[5:2]][8*(3 - bpos[1:0]) +: 8] <= pad_byte;
          bpos <= bpos + 1'b1;
          if (bpos == 6'd63) begin
            final_blk <= len_here;
            pend_len  <= !len_here;
            state     <= S_COMP;
          end
        end
        S_COMP: begin
          if (done) begin
            bpos <= '0;
            if (final_blk) begin
              oidx  <= '0;
              state <= S_OUT;
            end else if (pend_len) begin
              state <= S_LEN;
            end else begin
              state <= S_BYTE;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 1'b1;
            if (oidx == 3'd7) begin
              count <= '0;
              fresh <= 1'b1;
              bpos  <= '0;
              state <= S_BYTE;
            end
          end
        end
        default: state <= S_BYTE;
      endcase
    end
  end

  a_out_only_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !busy) else $error("digest shown mid compression");
  a_comp_started: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.start)) |-> busy) else $error("compression did not start");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !busy) else $error("byte taken while compressing");

endmodule

// ===== design/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 over a byte stream. One byte per cycle enters a QueueDepth-deep
// queue (4 by default) unless in_stall is high; the back end stores one byte
// per cycle while in its byte state and the queue holds one, and runs a
// compression on each full block, draining no bytes meanwhile. End of message
// adds padding blocks, each followed by its compression, then the eight digest
// words leave one per cycle unless out_stall, index 0 first, last_word on index 7.
module sha256_byte_stream_hasher_unit
  import sha_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha_item_t q_item;
  logic      q_valid, q_take;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(in_valid), .wr_stall(in_stall),
    .wr_item('{data_byte: data_byte, byte_present: byte_present,
               end_of_message: end_of_message}),
    .rd_valid(q_valid), .rd_take(q_take), .rd_item(q_item)
  );

  sha_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

endmodule
